// ===== hdl/nsc_pkg.sv =====
// Shared types, constants and helpers for the natural sort compare core.
package nsc_pkg;

    localparam int CHARS_W = 64;
    localparam int LEN_W   = 4;
    localparam int BYTE_W  = 8;
    // Eight decimal digits at most: 99999999 fits in 27 bits.
    localparam int NUM_W   = 27;

    localparam logic [BYTE_W-1:0] DIGIT_LO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_HI = 8'h39;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LETTER,
        S_NUM_L,
        S_NUM_R,
        S_CMP,
        S_DONE
    } t_state;

    // Control from the top level into the sequencer.
    typedef struct packed {
        logic start;
        logic load_ok;
    } t_seq_ctl;

    // Status from the sequencer back to the top level.
    typedef struct packed {
        logic busy;
        logic done;
        logic less;
    } t_seq_sts;

    function automatic logic f_is_digit(input logic [BYTE_W-1:0] c);
        return (c >= DIGIT_LO) && (c <= DIGIT_HI);
    endfunction

endpackage

// ===== hdl/natural_sort_compare_core.sv =====
// Top level of the natural sort compare core: handshakes, length clamp and result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_left_chars, i_left_len,
//           |           |                           | i_right_chars, i_right_len
//   out     | output    | o_out_valid / i_out_stall | o_left_less
//
// With the output not stalled, an item passes through these steps in order: the idle
// state accepts it; the letter walk steps over each matching character pair, starts
// each digit run and stops at a string end; each digit run is read on the left side and
// then on the right side through the single shared times-ten accumulator; each pair of
// numbers is compared; and the result is handed over. The item that takes longest is a
// string such as 1a1a1a11 against itself.
// The input stalls while the sequencer works on an item.
// Reset is synchronous and active low; it empties the result register and returns
// the sequencer to idle. A finished result sits in the output register until it is
// taken, so the next item can be accepted while the result waits.
module natural_sort_compare_core #(
    parameter int MAX_CHARS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [nsc_pkg::CHARS_W-1:0] i_left_chars,
    input  logic [nsc_pkg::LEN_W-1:0]   i_left_len,
    input  logic [nsc_pkg::CHARS_W-1:0] i_right_chars,
    input  logic [nsc_pkg::LEN_W-1:0]   i_right_len,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_left_less
);
    import nsc_pkg::*;

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_CHARS);

    t_seq_ctl         w_ctl;
    t_seq_sts         w_sts;
    logic [LEN_W-1:0] w_left_len;
    logic [LEN_W-1:0] w_right_len;
    logic             r_out_valid, n_out_valid;
    logic             r_out_less, n_out_less;
    logic             w_load;

    // Lengths beyond the string capacity are treated as full strings.
    assign w_left_len  = (i_left_len  > MaxLen) ? MaxLen : i_left_len;
    assign w_right_len = (i_right_len > MaxLen) ? MaxLen : i_right_len;

    assign o_in_stall    = w_sts.busy;
    assign w_ctl.start   = i_in_valid && !w_sts.busy;
    // The result register can take a new result when empty or being drained.
    assign w_ctl.load_ok = !r_out_valid || !i_out_stall;
    assign w_load        = w_sts.done && w_ctl.load_ok;

    nsc_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_left_chars  (i_left_chars),
        .i_left_len    (w_left_len),
        .i_right_chars (i_right_chars),
        .i_right_len   (w_right_len),
        .o_sts         (w_sts)
    );

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_less  = r_out_less;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_less  = w_sts.less;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_less <= n_out_less;
    end

    assign o_out_valid = r_out_valid;
    assign o_left_less = r_out_less;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid)
        else $error("finished item did not reach the output register");

    a_rose_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_sts.done))
        else $error("result appeared without a finished item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted item did not occupy the sequencer");

endmodule

// ===== hdl/nsc_acc.sv =====
// Shared decimal accumulator: next value is value times ten plus one digit.
module nsc_acc (
    input  logic [nsc_pkg::NUM_W-1:0]  i_value,
    input  logic [nsc_pkg::BYTE_W-1:0] i_char,
    output logic [nsc_pkg::NUM_W-1:0]  o_value
);
    import nsc_pkg::*;

    logic [BYTE_W-1:0] w_digit;
    logic [NUM_W-1:0]  w_x8;
    logic [NUM_W-1:0]  w_x2;

    // Times ten is built from two shifts and an add.
    assign w_digit = i_char - DIGIT_LO;
    assign w_x8    = {i_value[NUM_W-4:0], 3'b000};
    assign w_x2    = {i_value[NUM_W-2:0], 1'b0};
    assign o_value = w_x8 + w_x2 + NUM_W'(w_digit);

endmodule

// ===== hdl/nsc_seq.sv =====
// Sequencer that walks both strings and reads digit runs through the shared accumulator.
module nsc_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nsc_pkg::t_seq_ctl           i_ctl,
    input  logic [nsc_pkg::CHARS_W-1:0] i_left_chars,
    input  logic [nsc_pkg::LEN_W-1:0]   i_left_len,
    input  logic [nsc_pkg::CHARS_W-1:0] i_right_chars,
    input  logic [nsc_pkg::LEN_W-1:0]   i_right_len,
    output nsc_pkg::t_seq_sts           o_sts
);
    import nsc_pkg::*;

    t_state r_state, n_state;
    logic [CHARS_W-1:0] r_lc, n_lc;
    logic [CHARS_W-1:0] r_rc, n_rc;
    logic [LEN_W-1:0]   r_ll, n_ll;
    logic [LEN_W-1:0]   r_rl, n_rl;
    logic [LEN_W-1:0]   r_li, n_li;
    logic [LEN_W-1:0]   r_ri, n_ri;
    logic [NUM_W-1:0]   r_lv, n_lv;
    logic [NUM_W-1:0]   r_rv, n_rv;
    logic               r_less, n_less;

    logic [BYTE_W-1:0]  w_a, w_b;
    logic               w_ad, w_bd;
    logic               w_l_more, w_r_more;
    logic [NUM_W-1:0]   w_acc_in, w_acc_out;
    logic [BYTE_W-1:0]  w_acc_char;

    assign w_a      = r_lc[{r_li[2:0], 3'b000} +: BYTE_W];
    assign w_b      = r_rc[{r_ri[2:0], 3'b000} +: BYTE_W];
    assign w_ad     = f_is_digit(w_a);
    assign w_bd     = f_is_digit(w_b);
    assign w_l_more = r_li < r_ll;
    assign w_r_more = r_ri < r_rl;

    // One accumulator serves the left run and then the right run.
    assign w_acc_in   = (r_state == S_NUM_R) ? r_rv : r_lv;
    assign w_acc_char = (r_state == S_NUM_R) ? w_b : w_a;

    nsc_acc u_acc (
        .i_value (w_acc_in),
        .i_char  (w_acc_char),
        .o_value (w_acc_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lc   <= n_lc;
        r_rc   <= n_rc;
        r_ll   <= n_ll;
        r_rl   <= n_rl;
        r_li   <= n_li;
        r_ri   <= n_ri;
        r_lv   <= n_lv;
        r_rv   <= n_rv;
        r_less <= n_less;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_state = S_LETTER;
                end
            end
            S_LETTER: begin
                if (!w_l_more || !w_r_more) begin
                    n_state = S_DONE;
                end else if (w_ad && w_bd) begin
                    n_state = S_NUM_L;
                end else if (w_ad || w_bd || (w_a != w_b)) begin
                    n_state = S_DONE;
                end
            end
            S_NUM_L: begin
                if (!(w_l_more && w_ad)) begin
                    n_state = S_NUM_R;
                end
            end
            S_NUM_R: begin
                if (!(w_r_more && w_bd)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = (r_lv == r_rv) ? S_LETTER : S_DONE;
            end
            S_DONE: begin
                if (i_ctl.load_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and status.
    always_comb begin
        n_lc   = r_lc;
        n_rc   = r_rc;
        n_ll   = r_ll;
        n_rl   = r_rl;
        n_li   = r_li;
        n_ri   = r_ri;
        n_lv   = r_lv;
        n_rv   = r_rv;
        n_less = r_less;
        o_sts.busy = (r_state != S_IDLE);
        o_sts.done = (r_state == S_DONE);
        o_sts.less = r_less;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_lc = i_left_chars;
                    n_rc = i_right_chars;
                    n_ll = i_left_len;
                    n_rl = i_right_len;
                    n_li = '0;
                    n_ri = '0;
                end
            end
            S_LETTER: begin
                if (!w_l_more || !w_r_more) begin
                    n_less = w_r_more;
                end else if (w_ad && w_bd) begin
                    n_lv = '0;
                    n_rv = '0;
                end else if (w_ad) begin
                    n_less = 1'b1;
                end else if (w_bd) begin
                    n_less = 1'b0;
                end else if (w_a != w_b) begin
                    n_less = (w_a < w_b);
                end else begin
                    n_li = r_li + LEN_W'(1);
                    n_ri = r_ri + LEN_W'(1);
                end
            end
            S_NUM_L: begin
                if (w_l_more && w_ad) begin
                    n_lv = w_acc_out;
                    n_li = r_li + LEN_W'(1);
                end
            end
            S_NUM_R: begin
                if (w_r_more && w_bd) begin
                    n_rv = w_acc_out;
                    n_ri = r_ri + LEN_W'(1);
                end
            end
            S_CMP: begin
                n_less = (r_lv < r_rv);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == S_IDLE))
        else $error("start while the sequencer is busy");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ((r_li <= r_ll) && (r_ri <= r_rl)))
        else $error("character position ran past the string length");

    a_num_r_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NUM_R) |=> ((r_state == S_NUM_R) || (r_state == S_CMP)))
        else $error("right digit run left without a compare");

endmodule
